/* design/ssl_pkg.sv */
// Shared types, constants and fixed-point helpers for the surface scan line generator.
package ssl_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MIN_POINTS = 2;
  localparam int IDX_W      = 6;
  localparam int NPTS_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int DVD_W      = 32;
  localparam int DVS_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_SHAPE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_PER_LINE = 2'd1;

  localparam logic signed [31:0] Q13_ONE  = 32'sd8192;
  localparam logic signed [31:0] Q13_HALF = 32'sd4096;
  localparam logic signed [31:0] Q30_ONE  = 32'sd1073741824;
  localparam logic signed [31:0] K_0P3    = 32'sd2458;
  localparam logic signed [31:0] K_0P2    = 32'sd1638;
  localparam logic signed [31:0] K_0P25   = 32'sd2048;
  localparam logic signed [31:0] K_TWO    = 32'sd16384;
  localparam logic signed [31:0] Q17_HALF = 32'sd65536;
  localparam logic signed [31:0] SIN_C4   = 32'sd172272;
  localparam logic [3:0]         EXP_TERMS = 4'd10;

  typedef enum logic [2:0] {
    SHAPE_FLAT   = 3'd0,
    SHAPE_SINCOS = 3'd1,
    SHAPE_WAVE   = 3'd2,
    SHAPE_RIPPLE = 3'd3,
    SHAPE_TUBE   = 3'd4,
    SHAPE_BELL   = 3'd5,
    SHAPE_SPIRAL = 3'd6,
    SHAPE_SPRING = 3'd7
  } shape_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_UDIV, ST_UWAIT, ST_DISP, ST_OUT,
    ST_SN0, ST_SN1, ST_SN2, ST_SN3,
    ST_SC1, ST_SC2, ST_SC3, ST_SC4, ST_SC5,
    ST_WV1, ST_WV2, ST_WV3,
    ST_RP1, ST_RP2, ST_RP3, ST_RP4, ST_RP5, ST_RP6, ST_RP7, ST_RP8,
    ST_TB1, ST_TB2, ST_TB3, ST_TB4, ST_TB5, ST_TB6,
    ST_BL1, ST_BL2, ST_BL3, ST_BL4, ST_BL5, ST_BL6, ST_BL7, ST_BL8,
    ST_SP1, ST_SP2, ST_SP3, ST_SP4, ST_SP5, ST_SP6, ST_SP7, ST_SP8,
    ST_SG1, ST_SG2, ST_SG3, ST_SG4, ST_SG5, ST_SG6, ST_SG7
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
  } div_rsp_t;

  // Horner coefficients of sin(pi*z/2) in Q30, lowest order first
  function automatic logic signed [31:0] sin_coef(input logic [1:0] k);
    logic signed [31:0] c;
    unique case (k)
      2'd0: c = 32'sd1686629713;
      2'd1: c = 32'sd693598669;
      2'd2: c = 32'sd85569306;
      2'd3: c = 32'sd5026996;
      default: c = 32'sd0;
    endcase
    return c;
  endfunction

  // Q13 product rescale, round half away from zero
  function automatic logic signed [31:0] rnd13(input logic signed [63:0] pr);
    logic signed [63:0] mag;
    logic signed [63:0] q;
    mag = (pr < 0) ? -pr : pr;
    q = (mag + 64'sd4096) >>> 13;
    if (pr < 0) q = -q;
    return q[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) r = 16'sh7fff;
    else if (v < -32'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // Half-turn angle modulo two: the low 14 bits
  function automatic logic [13:0] lo14(input logic signed [31:0] a);
    return a[13:0];
  endfunction

endpackage

/* design/surface_scan_line_generator.sv */
// Top level: configuration registers and the vertex sequencer.
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------------------------
//   input    | in_valid / in_stall | scan_pos, phase
//   output   | out_valid/out_stall | x_coord, y_coord, z_coord, point_index, last_point
//   config   | cfg_we              | cfg_index, cfg_data
//
// One input transaction yields a line of points_per_line vertices (2 to 64), computed
// one vertex at a time. Each vertex runs its u divide on the 32-step divider, a set-up
// state and the output state, plus a sine evaluation for each sine term and any further
// divides of its shape; flat needs neither, and bell's series takes ten divides.
// The sequencer holds in its output state while the output is stalled.
// in_stall stays high from acceptance until the last vertex is taken.
// rst is synchronous; it returns the sequencer to idle and the registers to defaults.
// A stalled vertex holds on the output ports until taken.
module surface_scan_line_generator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [15:0]              scan_pos,
  input  logic signed [15:0]              phase,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [15:0]              x_coord,
  output logic signed [15:0]              y_coord,
  output logic signed [15:0]              z_coord,
  output logic [ssl_pkg::IDX_W-1:0]       point_index,
  output logic                            last_point,
  input  logic                            cfg_we,
  input  logic [ssl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ssl_pkg::*;

  shape_t             plane_shape;
  logic [NPTS_W-1:0]  points_per_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_shape     <= SHAPE_FLAT;
      points_per_line <= NPTS_W'(MAX_POINTS);
    end else if (cfg_we) begin
      // drop writes to unknown indexes
      priority if (cfg_index == CFG_PLANE_SHAPE) begin
        plane_shape <= shape_t'(cfg_data[2:0]);
      end else if (cfg_index == CFG_POINTS_PER_LINE) begin
        points_per_line <= cfg_data;
      end
    end
  end

  ssl_core u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .scan_pos    (scan_pos),
    .phase       (phase),
    .shape       (plane_shape),
    .npts_cfg    (points_per_line),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .z_coord     (z_coord),
    .point_index (point_index),
    .last_point  (last_point)
  );

endmodule

/* design/ssl_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module ssl_div (
  input  logic              clk,
  input  logic              rst,
  input  ssl_pkg::div_req_t req,
  output ssl_pkg::div_rsp_t rsp
);
  import ssl_pkg::*;

  logic                busy;
  logic                done;
  logic [4:0]          cnt;
  logic [DVD_W-1:0]    dvd;
  logic [DVS_W:0]      rem;
  logic [DVS_W-1:0]    dvs;
  logic [DVS_W:0]      rem_sh;
  logic                qbit;

  assign rem_sh = {rem[DVS_W-1:0], dvd[DVD_W-1]};
  assign qbit   = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
        dvd  <= req.dividend;
        dvs  <= req.divisor;
        rem  <= '0;
      end else if (busy) begin
        rem <= qbit ? (rem_sh - {1'b0, dvs}) : rem_sh;
        dvd <= {dvd[DVD_W-2:0], qbit};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dvd;

endmodule

/* design/ssl_core.sv */
// Sequencer and shared multiplier that evaluate the surface one vertex at a time.
module ssl_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [15:0]           scan_pos,
  input  logic signed [15:0]           phase,
  input  ssl_pkg::shape_t              shape,
  input  logic [ssl_pkg::NPTS_W-1:0]   npts_cfg,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [15:0]           x_coord,
  output logic signed [15:0]           y_coord,
  output logic signed [15:0]           z_coord,
  output logic [ssl_pkg::IDX_W-1:0]    point_index,
  output logic                         last_point
);
  import ssl_pkg::*;

  state_t state, state_next, ret;

  logic [IDX_W-1:0]   idx;
  logic [NPTS_W-1:0]  npts;
  shape_t             shape_r;
  logic signed [15:0] u_r, v_r, p_r;
  logic signed [31:0] x_r, y_r, z_r, t0, t1;
  logic [13:0]        sin_arg;
  logic signed [31:0] zq, z2;
  logic [1:0]         kcnt;
  logic               sneg;
  logic signed [14:0] sin_res;
  logic [31:0]        sq_n, sq_res;
  logic [30:0]        sq_bit;
  logic signed [31:0] eq;
  logic [3:0]         ek;
  logic [1:0]         sqc;
  logic               rneg;
  logic signed [63:0] prod;

  logic signed [31:0] mul_a, mul_b;
  logic               sin_load;
  logic [13:0]        sin_next;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic signed [31:0] u32, v32, p32, m13, sh30, rnd17, s_cap, hp_c, zc, rp_mag;
  logic [13:0]        rr14;
  logic signed [15:0] v_clamp;
  logic [NPTS_W-1:0]  npts_eff;
  logic               is_last;
  logic [31:0]        sq_try;

  ssl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign u32   = 32'(u_r);
  assign v32   = 32'(v_r);
  assign p32   = 32'(p_r);
  assign m13   = rnd13(prod);
  assign sh30  = prod[61:30];
  assign rnd17 = (sh30 + Q17_HALF) >>> 17;
  assign s_cap = (rnd17 > Q13_ONE) ? Q13_ONE : rnd17;
  assign hp_c  = sin_coef(kcnt) - sh30;
  // fold to the first quarter wave
  assign rr14  = (sin_arg[12:0] > 13'd4096) ? (14'd8192 - {1'b0, sin_arg[12:0]})
                                            : {1'b0, sin_arg[12:0]};
  assign zc    = 32'(rr14) <<< 18;
  assign rp_mag = ((m13 < 0) ? -m13 : m13) <<< 13;
  assign sq_try = sq_res + {1'b0, sq_bit};

  assign v_clamp  = (scan_pos < -16'sd8192) ? -16'sd8192 :
                    (scan_pos > 16'sd8192) ? 16'sd8192 : scan_pos;
  assign npts_eff = (npts_cfg < NPTS_W'(MIN_POINTS)) ? NPTS_W'(MIN_POINTS) :
                    (npts_cfg > NPTS_W'(MAX_POINTS)) ? NPTS_W'(MAX_POINTS) : npts_cfg;
  assign is_last  = ({1'b0, idx} == (npts - 7'd1));

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_UDIV;
      ST_UDIV:  state_next = ST_UWAIT;
      ST_UWAIT: if (div_rsp.done) state_next = ST_DISP;
      ST_DISP: begin
        unique case (shape_r)
          SHAPE_FLAT:   state_next = ST_OUT;
          SHAPE_SINCOS: state_next = ST_SC1;
          SHAPE_WAVE:   state_next = ST_WV1;
          SHAPE_RIPPLE: state_next = ST_RP1;
          SHAPE_TUBE:   state_next = ST_TB1;
          SHAPE_BELL:   state_next = ST_BL1;
          SHAPE_SPIRAL: state_next = ST_SP1;
          SHAPE_SPRING: state_next = ST_SG1;
          default:      state_next = ST_OUT;
        endcase
      end
      ST_OUT: if (!out_stall) state_next = is_last ? ST_IDLE : ST_UDIV;
      ST_SN0: state_next = ST_SN1;
      ST_SN1: state_next = ST_SN2;
      ST_SN2: if (kcnt == 2'd0) state_next = ST_SN3;
      ST_SN3: state_next = ret;
      ST_SC1: state_next = ST_SN0;
      ST_SC2: state_next = ST_SN0;
      ST_SC3: state_next = ST_SC4;
      ST_SC4: state_next = ST_SC5;
      ST_SC5: state_next = ST_OUT;
      ST_WV1: state_next = ST_SN0;
      ST_WV2: state_next = ST_WV3;
      ST_WV3: state_next = ST_OUT;
      ST_RP1: state_next = ST_RP2;
      ST_RP2: state_next = ST_RP3;
      ST_RP3: state_next = ST_RP4;
      ST_RP4: if (sq_bit == 31'd1) state_next = ST_RP5;
      ST_RP5: state_next = ST_SN0;
      ST_RP6: state_next = ST_RP7;
      ST_RP7: state_next = ST_RP8;
      ST_RP8: if (div_rsp.done) state_next = ST_OUT;
      ST_TB1: state_next = ST_TB2;
      ST_TB2: state_next = ST_SN0;
      ST_TB3: state_next = ST_TB4;
      ST_TB4: state_next = ST_SN0;
      ST_TB5: state_next = ST_TB6;
      ST_TB6: state_next = ST_OUT;
      ST_BL1: state_next = ST_BL2;
      ST_BL2: state_next = ST_BL3;
      ST_BL3: state_next = ST_BL4;
      ST_BL4: state_next = ST_BL5;
      ST_BL5: if (div_rsp.done) state_next = (ek == 4'd1) ? ST_BL6 : ST_BL4;
      ST_BL6: state_next = ST_BL7;
      ST_BL7: if (sqc == 2'd2) state_next = ST_BL8;
      ST_BL8: state_next = ST_OUT;
      ST_SP1: state_next = ST_SP2;
      ST_SP2: state_next = ST_SP3;
      ST_SP3: state_next = ST_SN0;
      ST_SP4: state_next = ST_SP5;
      ST_SP5: state_next = ST_SN0;
      ST_SP6: state_next = ST_SP7;
      ST_SP7: state_next = ST_SP8;
      ST_SP8: state_next = ST_OUT;
      ST_SG1: state_next = ST_SG2;
      ST_SG2: state_next = ST_SN0;
      ST_SG3: state_next = ST_SG4;
      ST_SG4: state_next = ST_SN0;
      ST_SG5: state_next = ST_SG6;
      ST_SG6: state_next = ST_SG7;
      ST_SG7: state_next = ST_OUT;
      default: state_next = ST_IDLE;
    endcase
  end

  // handshakes, multiplier operands, divider requests, sine argument
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    sin_load  = 1'b0;
    sin_next  = '0;
    div_req   = '0;
    unique case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_UDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = 32'({idx, 15'b0}) + 32'(npts - 7'd1);
        div_req.divisor  = 16'({npts - 7'd1, 1'b0});
      end
      ST_OUT: out_valid = 1'b1;
      ST_SN0: begin
        mul_a = zc;
        mul_b = zc;
      end
      ST_SN1: begin
        mul_a = SIN_C4;
        mul_b = sh30;
      end
      ST_SN2: begin
        mul_a = hp_c;
        mul_b = (kcnt == 2'd0) ? zq : z2;
      end
      ST_SC1: begin
        sin_load = 1'b1;
        sin_next = lo14((u32 + p32) <<< 1);
      end
      ST_SC2: begin
        sin_load = 1'b1;
        sin_next = lo14(((v32 + p32) <<< 1) + Q13_HALF);
      end
      ST_SC3: begin
        mul_a = t0;
        mul_b = 32'(sin_res);
      end
      ST_SC4: begin
        mul_a = K_0P3;
        mul_b = m13;
      end
      ST_WV1: begin
        sin_load = 1'b1;
        sin_next = lo14(32'sd3 * (u32 + v32 + p32));
      end
      ST_WV2: begin
        mul_a = K_0P2;
        mul_b = 32'(sin_res);
      end
      ST_RP1: begin
        mul_a = u32;
        mul_b = u32;
      end
      ST_RP2: begin
        mul_a = v32;
        mul_b = v32;
      end
      ST_RP5: begin
        sin_load = 1'b1;
        sin_next = lo14(($signed(sq_res) - p32) <<< 2);
      end
      ST_RP6: begin
        mul_a = K_0P25;
        mul_b = 32'(sin_res);
      end
      ST_RP7: begin
        div_req.start    = 1'b1;
        div_req.dividend = rp_mag + Q13_HALF + t1;
        div_req.divisor  = 16'(Q13_ONE + (t1 <<< 1));
      end
      ST_TB1: begin
        mul_a = p32;
        mul_b = K_0P2;
      end
      ST_TB2: begin
        sin_load = 1'b1;
        sin_next = lo14(v32 + Q13_HALF);
      end
      ST_TB3, ST_TB5, ST_SG3, ST_SG5: begin
        mul_a = 32'(sin_res);
        mul_b = t0;
      end
      ST_TB4: begin
        sin_load = 1'b1;
        sin_next = lo14(v32);
      end
      ST_BL1: begin
        mul_a = p32;
        mul_b = Q13_HALF;
      end
      ST_BL2: begin
        mul_a = u32;
        mul_b = u32;
      end
      ST_BL3: begin
        mul_a = (m13 * 32'sd5) <<< 14;
        mul_b = Q30_ONE;
      end
      ST_BL4: begin
        div_req.start    = 1'b1;
        div_req.dividend = sh30;
        div_req.divisor  = 16'(ek);
      end
      ST_BL5: begin
        mul_a = t1;
        mul_b = Q30_ONE - $signed(div_rsp.quot);
      end
      ST_BL6: begin
        mul_a = eq;
        mul_b = eq;
      end
      ST_BL7: begin
        if (sqc == 2'd2) begin
          mul_a = t0;
          mul_b = rnd17;
        end else begin
          mul_a = sh30;
          mul_b = sh30;
        end
      end
      ST_SP1: begin
        mul_a = v32 + Q13_ONE;
        mul_b = K_TWO + (p32 <<< 1);
      end
      ST_SP2: begin
        mul_a = v32 + Q13_ONE;
        mul_b = Q13_HALF;
      end
      ST_SP3: begin
        sin_load = 1'b1;
        sin_next = lo14(t1 + Q13_HALF);
      end
      ST_SP4, ST_SP6: begin
        mul_a = t0;
        mul_b = 32'(sin_res);
      end
      ST_SP5: begin
        sin_load = 1'b1;
        sin_next = lo14(t1);
      end
      ST_SP7: begin
        mul_a = u32;
        mul_b = Q13_HALF;
      end
      ST_SG1: begin
        mul_a = u32;
        mul_b = K_0P2;
      end
      ST_SG2: begin
        sin_load = 1'b1;
        sin_next = lo14((v32 <<< 1) + Q13_HALF);
      end
      ST_SG4: begin
        sin_load = 1'b1;
        sin_next = lo14(v32 <<< 1);
      end
      ST_SG6: begin
        mul_a = v32;
        mul_b = Q13_ONE + p32;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (sin_load) sin_arg <= sin_next;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            v_r     <= v_clamp;
            p_r     <= phase;
            idx     <= '0;
            npts    <= npts_eff;
            shape_r <= shape;
          end
        end
        ST_UWAIT: if (div_rsp.done) u_r <= 16'($signed(div_rsp.quot) - Q13_ONE);
        ST_DISP: begin
          x_r <= u32;
          y_r <= '0;
          z_r <= v32;
        end
        ST_OUT: if (!out_stall) idx <= idx + 6'd1;
        ST_SN0: begin
          zq   <= zc;
          sneg <= sin_arg[13];
        end
        ST_SN1: begin
          z2   <= sh30;
          kcnt <= 2'd3;
        end
        ST_SN2: kcnt <= kcnt - 2'd1;
        ST_SN3: sin_res <= sneg ? -15'(s_cap) : 15'(s_cap);
        ST_SC1: ret <= ST_SC2;
        ST_SC2: begin
          t0  <= 32'(sin_res);
          ret <= ST_SC3;
        end
        ST_SC5: y_r <= m13;
        ST_WV1: ret <= ST_WV2;
        ST_WV3: y_r <= m13;
        ST_RP2: t0 <= prod[31:0];
        ST_RP3: begin
          sq_n   <= t0 + prod[31:0];
          sq_res <= '0;
          sq_bit <= 31'h4000_0000;
        end
        ST_RP4: begin
          if (sq_n >= sq_try) begin
            sq_n   <= sq_n - sq_try;
            sq_res <= (sq_res >> 1) + {1'b0, sq_bit};
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
        end
        ST_RP5: begin
          t1  <= $signed(sq_res);
          ret <= ST_RP6;
        end
        ST_RP7: rneg <= (m13 < 0);
        ST_RP8: begin
          if (div_rsp.done) begin
            y_r <= rneg ? -$signed(div_rsp.quot) : $signed(div_rsp.quot);
          end
        end
        ST_TB2: begin
          t0  <= Q13_HALF + m13;
          ret <= ST_TB3;
        end
        ST_TB4: begin
          y_r <= m13;
          ret <= ST_TB5;
        end
        ST_TB6: z_r <= m13;
        ST_BL2: t0 <= Q13_HALF + m13;
        ST_BL3: begin
          t1 <= (m13 * 32'sd5) <<< 14;
          ek <= EXP_TERMS;
        end
        ST_BL5: begin
          if (div_rsp.done) begin
            eq <= Q30_ONE - $signed(div_rsp.quot);
            ek <= ek - 4'd1;
          end
        end
        ST_BL6: sqc <= 2'd0;
        ST_BL7: begin
          eq  <= sh30;
          sqc <= sqc + 2'd1;
        end
        ST_BL8: y_r <= m13;
        ST_SP2: t1 <= m13;
        ST_SP3: begin
          t0  <= m13;
          ret <= ST_SP4;
        end
        ST_SP5: begin
          x_r <= m13;
          ret <= ST_SP6;
        end
        ST_SP7: y_r <= m13;
        ST_SP8: z_r <= m13;
        ST_SG2: begin
          t0  <= Q13_HALF + m13;
          ret <= ST_SG3;
        end
        ST_SG4: begin
          x_r <= m13;
          ret <= ST_SG5;
        end
        ST_SG6: z_r <= m13;
        ST_SG7: y_r <= m13;
        default: ;
      endcase
    end
  end

  assign x_coord     = sat16(x_r);
  assign y_coord     = sat16(y_r);
  assign z_coord     = sat16(z_r);
  assign point_index = idx;
  assign last_point  = is_last;

endmodule

/* design/ssl_checker.sv */
// Port-level checks for the surface scan line generator, bound to the top level.
module ssl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic signed [15:0]              x_coord,
  input logic [ssl_pkg::IDX_W-1:0]       point_index,
  input logic                            last_point
);
  import ssl_pkg::*;

  // a stalled vertex holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(x_coord) && $stable(point_index))
    else $error("stalled vertex changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a line is in progress");

  a_no_vertex_when_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("vertex shown while idle");

  a_gap_after_vertex: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid)
    else $error("vertex repeated without computation");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_point |=> !in_stall)
    else $error("input not freed after the last vertex");

endmodule

bind surface_scan_line_generator ssl_checker u_ssl_checker (.*);
